// File: design/tac_pkg.sv
package tac_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 7;
  localparam int CORDIC_STEPS_DEF    = 16;

  localparam int SAMPLE_W   = 16;
  localparam int GUARD_BITS = 8;
  localparam int VEC_W      = 28;
  localparam int ACC_W      = 28;
  localparam int GAIN_W     = 17;
  localparam int GAIN_FRAC  = 16;
  localparam int PROD_W     = VEC_W + GAIN_W;
  localparam int TABLE_LEN  = 24;
  localparam int IDX_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 16;
  localparam int DWELL_W    = 16;
  localparam int SEC_W      = 6;
  localparam int MIN_W      = 6;
  localparam int HOUR_W     = 16;
  localparam int ROLL_W     = 16;
  localparam int PITCH_W    = 15;

  localparam int SECS_PER_MIN  = 60;
  localparam int MINS_PER_HOUR = 60;

  localparam logic signed [GAIN_W-1:0] INV_GAIN_Q16 = 17'sd39797;
  localparam logic signed [ACC_W-1:0]  DEG90_Q16    = 28'sd5898240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_THR = 3'd0,
    REG_ROLL_LO    = 3'd1,
    REG_ROLL_HI    = 3'd2,
    REG_PITCH_LO   = 3'd3,
    REG_PITCH_HI   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LVL_REST   = 2'd0,
    LVL_ACTIVE = 2'd1,
    LVL_HIGH   = 2'd2
  } level_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] active_thr;
    logic signed [CFG_W-1:0] roll_lo;
    logic signed [CFG_W-1:0] roll_hi;
    logic signed [CFG_W-1:0] pitch_lo;
    logic signed [CFG_W-1:0] pitch_hi;
  } cfg_regs_t;

  typedef struct packed {
    logic             accept;
    logic             iter;
    logic             mul;
    logic             load_pitch;
    logic             conv;
    logic             commit;
    logic [IDX_W-1:0] step;
  } dp_cmd_t;

  // Elementary angles atan(2^-i) in degrees scaled by 2^16.
  function automatic logic signed [ACC_W-1:0] atan_deg_q16(input logic [IDX_W-1:0] idx);
    logic signed [ACC_W-1:0] v;
    unique case (idx)
      5'd0:    v = 28'sd2949120;
      5'd1:    v = 28'sd1740967;
      5'd2:    v = 28'sd919879;
      5'd3:    v = 28'sd466945;
      5'd4:    v = 28'sd234379;
      5'd5:    v = 28'sd117304;
      5'd6:    v = 28'sd58666;
      5'd7:    v = 28'sd29335;
      5'd8:    v = 28'sd14668;
      5'd9:    v = 28'sd7334;
      5'd10:   v = 28'sd3667;
      5'd11:   v = 28'sd1833;
      5'd12:   v = 28'sd917;
      5'd13:   v = 28'sd458;
      5'd14:   v = 28'sd229;
      5'd15:   v = 28'sd115;
      5'd16:   v = 28'sd57;
      5'd17:   v = 28'sd29;
      5'd18:   v = 28'sd14;
      5'd19:   v = 28'sd7;
      5'd20:   v = 28'sd4;
      5'd21:   v = 28'sd2;
      5'd22:   v = 28'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: design/tac_ifs.sv
interface tac_in_if;
  import tac_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] accel_x;
  logic signed [SAMPLE_W-1:0] accel_y;
  logic signed [SAMPLE_W-1:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tac_out_if;
  import tac_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                activity_level;
  logic [DWELL_W-1:0]        dwell_seconds;
  logic signed [ROLL_W-1:0]  roll_angle;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic [SEC_W-1:0]          elapsed_seconds;
  logic [MIN_W-1:0]          elapsed_minutes;
  logic [HOUR_W-1:0]         elapsed_hours;
  modport source (output valid, activity_level, dwell_seconds, roll_angle, pitch_angle,
                  elapsed_seconds, elapsed_minutes, elapsed_hours, input ready);
  modport sink   (input valid, activity_level, dwell_seconds, roll_angle, pitch_angle,
                  elapsed_seconds, elapsed_minutes, elapsed_hours, output ready);
endinterface

interface tac_cfg_if;
  import tac_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/tilt_activity_classifier.sv
// Channel   Interface   Role    Beat moves
// in_s      tac_in_if   sink    one sample: accel_x, accel_y, accel_z
// out_s     tac_out_if  source  one result: class, dwell, roll, pitch, elapsed clock
// cfg_s     tac_cfg_if  sink    one register write: index, data
//
// The next sample is accepted only once the previous one is committed; the single shared
// CORDIC stage runs CORDIC_STEPS iterations for roll and again for pitch, with one gain
// multiply in between.
// Reset is synchronous on rst_n and restores the register defaults, the dwell count and
// the elapsed clock. Configuration writes are taken in every cycle.
// A new sample is accepted while the previous result waits on out_s; a sample only
// holds in its last cycle if the result before it has still not been taken.
module tilt_activity_classifier #(
  parameter int ANGLE_FRAC_BITS = tac_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = tac_pkg::CORDIC_STEPS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  tac_in_if.sink    in_s,
  tac_out_if.source out_s,
  tac_cfg_if.sink   cfg_s
);
  import tac_pkg::*;

  dp_cmd_t   cmd;
  logic      out_free;
  cfg_regs_t cfg_regs;

  assign cfg_s.ready = 1'b1;

  tac_cfg #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_s.valid && cfg_s.ready),
    .wr_idx  (cfg_s.index),
    .wr_data (cfg_s.data),
    .regs    (cfg_regs)
  );

  tac_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_s.ready),
    .out_free (out_free),
    .cmd      (cmd)
  );

  tac_dp #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .out_free  (out_free),
    .in_x      (in_s.accel_x),
    .in_y      (in_s.accel_y),
    .in_z      (in_s.accel_z),
    .cfg       (cfg_regs),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .out_level (out_s.activity_level),
    .out_dwell (out_s.dwell_seconds),
    .out_roll  (out_s.roll_angle),
    .out_pitch (out_s.pitch_angle),
    .out_sec   (out_s.elapsed_seconds),
    .out_min   (out_s.elapsed_minutes),
    .out_hour  (out_s.elapsed_hours)
  );

endmodule

// File: design/tac_cfg.sv
module tac_cfg #(
  parameter int ANGLE_FRAC_BITS = tac_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [tac_pkg::CFG_IDX_W-1:0]  wr_idx,
  input  logic [tac_pkg::CFG_W-1:0]      wr_data,
  output tac_pkg::cfg_regs_t             regs
);
  import tac_pkg::*;

  localparam logic signed [CFG_W-1:0] ACT_RST      = CFG_W'(10 << ANGLE_FRAC_BITS);
  localparam logic signed [CFG_W-1:0] ROLL_LO_RST  = CFG_W'(-(5 << ANGLE_FRAC_BITS));
  localparam logic signed [CFG_W-1:0] ROLL_HI_RST  = CFG_W'(2 << ANGLE_FRAC_BITS);
  localparam logic signed [CFG_W-1:0] PITCH_LO_RST = CFG_W'(-(3 << ANGLE_FRAC_BITS));
  localparam logic signed [CFG_W-1:0] PITCH_HI_RST = CFG_W'(3 << ANGLE_FRAC_BITS);

  cfg_regs_t regs_r, regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (wr_idx)
        REG_ACTIVE_THR: regs_nxt.active_thr = wr_data;
        REG_ROLL_LO:    regs_nxt.roll_lo    = wr_data;
        REG_ROLL_HI:    regs_nxt.roll_hi    = wr_data;
        REG_PITCH_LO:   regs_nxt.pitch_lo   = wr_data;
        REG_PITCH_HI:   regs_nxt.pitch_hi   = wr_data;
        default:        regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.active_thr <= ACT_RST;
      regs_r.roll_lo    <= ROLL_LO_RST;
      regs_r.roll_hi    <= ROLL_HI_RST;
      regs_r.pitch_lo   <= PITCH_LO_RST;
      regs_r.pitch_hi   <= PITCH_HI_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// File: design/tac_ctrl.sv
module tac_ctrl #(
  parameter int CORDIC_STEPS = tac_pkg::CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_free,
  output tac_pkg::dp_cmd_t cmd
);
  import tac_pkg::*;

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ROLL   = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_PLOAD  = 7'b0001000,
    S_PITCH  = 7'b0010000,
    S_CONV   = 7'b0100000,
    S_COMMIT = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_ROLL;
          step_nxt  = '0;
        end
      end
      S_ROLL: begin
        if (step_r == LAST_STEP) begin
          state_nxt = S_MUL;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_MUL: state_nxt = S_PLOAD;
      S_PLOAD: begin
        state_nxt = S_PITCH;
        step_nxt  = '0;
      end
      S_PITCH: begin
        if (step_r == LAST_STEP) begin
          state_nxt = S_CONV;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_CONV: state_nxt = S_COMMIT;
      S_COMMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    cmd.accept     = in_fire;
    cmd.iter       = (state_r == S_ROLL) || (state_r == S_PITCH);
    cmd.mul        = (state_r == S_MUL);
    cmd.load_pitch = (state_r == S_PLOAD);
    cmd.conv       = (state_r == S_CONV);
    cmd.commit     = (state_r == S_COMMIT) && out_free;
    cmd.step       = IDX_W'(step_r);
  end

  a_accept_starts_roll: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_ROLL) && (step_r == '0))
    else $error("accepted beat did not start the roll iterations");

  a_pitch_ends_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PITCH) && (step_r == LAST_STEP) |=> (state_r == S_CONV))
    else $error("pitch iterations did not hand over to conversion");

endmodule

// File: design/tac_dp.sv
module tac_dp #(
  parameter int ANGLE_FRAC_BITS = tac_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tac_pkg::dp_cmd_t                    cmd,
  output logic                                out_free,
  input  logic signed [tac_pkg::SAMPLE_W-1:0] in_x,
  input  logic signed [tac_pkg::SAMPLE_W-1:0] in_y,
  input  logic signed [tac_pkg::SAMPLE_W-1:0] in_z,
  input  tac_pkg::cfg_regs_t                  cfg,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_level,
  output logic [tac_pkg::DWELL_W-1:0]         out_dwell,
  output logic signed [tac_pkg::ROLL_W-1:0]   out_roll,
  output logic signed [tac_pkg::PITCH_W-1:0]  out_pitch,
  output logic [tac_pkg::SEC_W-1:0]           out_sec,
  output logic [tac_pkg::MIN_W-1:0]           out_min,
  output logic [tac_pkg::HOUR_W-1:0]          out_hour
);
  import tac_pkg::*;

  localparam int SHIFT = 16 - ANGLE_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (SHIFT - 1));
  localparam logic signed [ACC_W-1:0] ROLL_LIM   = ACC_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] PITCH_LIM  = ACC_W'(90 << ANGLE_FRAC_BITS);

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
  } vec_t;

  function automatic logic signed [VEC_W-1:0] scale_in(input logic signed [SAMPLE_W-1:0] s);
    logic signed [VEC_W-1:0] w;
    w = VEC_W'(s);
    return w <<< GUARD_BITS;
  endfunction

  // Left half-plane vectors are turned by a quarter turn first.
  function automatic vec_t prep(input logic signed [VEC_W-1:0] px,
                                input logic signed [VEC_W-1:0] py);
    vec_t r;
    r.zero = (px == '0) && (py == '0);
    r.x    = px;
    r.y    = py;
    r.acc  = '0;
    if (px < 0) begin
      if (py >= 0) begin
        r.x   = py;
        r.y   = -px;
        r.acc = DEG90_Q16;
      end else begin
        r.x   = -py;
        r.y   = px;
        r.acc = -DEG90_Q16;
      end
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] to_deg(input logic signed [ACC_W-1:0] a,
                                                     input logic signed [ACC_W-1:0] lim);
    logic signed [ACC_W-1:0] r;
    r = (a + ROUND_HALF) >>> SHIFT;
    if (r > lim) begin
      r = lim;
    end
    if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  logic signed [VEC_W-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt, roll_acc_r, roll_acc_nxt;
  logic                       zero_r, zero_nxt;
  logic signed [SAMPLE_W-1:0] ax_r, ax_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    roll_deg_r, roll_deg_nxt, pitch_deg_r, pitch_deg_nxt;
  logic signed [VEC_W-1:0]    horiz, xs, ys;
  logic signed [ACC_W-1:0]    step_angle;
  vec_t                       roll_prep, pitch_prep;

  level_t                     last_r, last_nxt, level;
  logic [DWELL_W-1:0]         dwell_r, dwell_nxt;
  logic [SEC_W-1:0]           sec_r, sec_nxt;
  logic [MIN_W-1:0]           min_r, min_nxt;
  logic [HOUR_W-1:0]          hour_r, hour_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 o_level_r, o_level_nxt;
  logic [DWELL_W-1:0]         o_dwell_r, o_dwell_nxt;
  logic signed [ROLL_W-1:0]   o_roll_r, o_roll_nxt;
  logic signed [PITCH_W-1:0]  o_pitch_r, o_pitch_nxt;
  logic [SEC_W-1:0]           o_sec_r, o_sec_nxt;
  logic [MIN_W-1:0]           o_min_r, o_min_nxt;
  logic [HOUR_W-1:0]          o_hour_r, o_hour_nxt;

  assign horiz      = prod_r[VEC_W+GAIN_FRAC-1:GAIN_FRAC];
  assign roll_prep  = prep(scale_in(in_z), scale_in(in_y));
  assign pitch_prep = prep(horiz, -scale_in(ax_r));
  assign xs         = x_r >>> cmd.step;
  assign ys         = y_r >>> cmd.step;
  assign step_angle = atan_deg_q16(cmd.step);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    zero_nxt = zero_r;
    ax_nxt   = ax_r;
    priority if (cmd.accept) begin
      x_nxt    = roll_prep.x;
      y_nxt    = roll_prep.y;
      acc_nxt  = roll_prep.acc;
      zero_nxt = roll_prep.zero;
      ax_nxt   = in_x;
    end else if (cmd.load_pitch) begin
      x_nxt    = pitch_prep.x;
      y_nxt    = pitch_prep.y;
      acc_nxt  = pitch_prep.acc;
      zero_nxt = pitch_prep.zero;
    end else if (cmd.iter) begin
      if (!y_r[VEC_W-1]) begin
        x_nxt   = x_r + ys;
        y_nxt   = y_r - xs;
        acc_nxt = acc_r + step_angle;
      end else begin
        x_nxt   = x_r - ys;
        y_nxt   = y_r + xs;
        acc_nxt = acc_r - step_angle;
      end
    end else begin
      x_nxt = x_r;
    end
  end

  always_comb begin
    prod_nxt      = prod_r;
    roll_acc_nxt  = roll_acc_r;
    roll_deg_nxt  = roll_deg_r;
    pitch_deg_nxt = pitch_deg_r;
    if (cmd.mul) begin
      prod_nxt     = x_r * INV_GAIN_Q16;
      roll_acc_nxt = zero_r ? '0 : acc_r;
    end
    if (cmd.conv) begin
      roll_deg_nxt  = to_deg(roll_acc_r, ROLL_LIM);
      pitch_deg_nxt = to_deg(zero_r ? '0 : acc_r, PITCH_LIM);
    end
  end

  always_comb begin
    priority if ((roll_deg_r > cfg.active_thr) || (pitch_deg_r > cfg.active_thr)) begin
      level = LVL_HIGH;
    end else if ((roll_deg_r > cfg.roll_lo) && (roll_deg_r < cfg.roll_hi) &&
                 (pitch_deg_r > cfg.pitch_lo) && (pitch_deg_r < cfg.pitch_hi)) begin
      level = LVL_REST;
    end else begin
      level = LVL_ACTIVE;
    end
  end

  always_comb begin
    last_nxt = last_r;
    dwell_nxt = dwell_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    if (cmd.commit) begin
      last_nxt = level;
      if (level != last_r) begin
        dwell_nxt = DWELL_W'(1);
      end else if (dwell_r != '1) begin
        dwell_nxt = dwell_r + DWELL_W'(1);
      end
      if (sec_r == SEC_W'(SECS_PER_MIN - 1)) begin
        sec_nxt = '0;
        if (min_r == MIN_W'(MINS_PER_HOUR - 1)) begin
          min_nxt = '0;
          if (hour_r != '1) begin
            hour_nxt = hour_r + HOUR_W'(1);
          end
        end else begin
          min_nxt = min_r + MIN_W'(1);
        end
      end else begin
        sec_nxt = sec_r + SEC_W'(1);
      end
    end
  end

  always_comb begin
    o_level_nxt = o_level_r;
    o_dwell_nxt = o_dwell_r;
    o_roll_nxt  = o_roll_r;
    o_pitch_nxt = o_pitch_r;
    o_sec_nxt   = o_sec_r;
    o_min_nxt   = o_min_r;
    o_hour_nxt  = o_hour_r;
    priority if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      o_level_nxt   = level;
      o_dwell_nxt   = dwell_nxt;
      o_roll_nxt    = roll_deg_r[ROLL_W-1:0];
      o_pitch_nxt   = pitch_deg_r[PITCH_W-1:0];
      o_sec_nxt     = sec_nxt;
      o_min_nxt     = min_nxt;
      o_hour_nxt    = hour_nxt;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    acc_r       <= acc_nxt;
    zero_r      <= zero_nxt;
    ax_r        <= ax_nxt;
    prod_r      <= prod_nxt;
    roll_acc_r  <= roll_acc_nxt;
    roll_deg_r  <= roll_deg_nxt;
    pitch_deg_r <= pitch_deg_nxt;
    o_level_r   <= o_level_nxt;
    o_dwell_r   <= o_dwell_nxt;
    o_roll_r    <= o_roll_nxt;
    o_pitch_r   <= o_pitch_nxt;
    o_sec_r     <= o_sec_nxt;
    o_min_r     <= o_min_nxt;
    o_hour_r    <= o_hour_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= LVL_REST;
      dwell_r     <= '0;
      sec_r       <= '0;
      min_r       <= '0;
      hour_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      last_r      <= last_nxt;
      dwell_r     <= dwell_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hour_r      <= hour_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_level = o_level_r;
  assign out_dwell = o_dwell_r;
  assign out_roll  = o_roll_r;
  assign out_pitch = o_pitch_r;
  assign out_sec   = o_sec_r;
  assign out_min   = o_min_r;
  assign out_hour  = o_hour_r;

  a_commit_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r && (dwell_r != '0) && (o_dwell_r == dwell_r))
    else $error("committed sample did not reach the output register");

  a_clock_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sec_r < SEC_W'(SECS_PER_MIN)) && (min_r < MIN_W'(MINS_PER_HOUR)))
    else $error("elapsed clock left its range");

endmodule

// File: verif/tilt_activity_checker.sv
module tilt_activity_checker (
  input  logic clk,
  input  logic rst_n,
  tac_in_if    in_ch,
  tac_out_if   out_ch,
  tac_cfg_if   cfg_ch,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import tac_pkg::*;

  localparam int     FRAC        = ANGLE_FRAC_BITS_DEF;
  localparam int     STEPS       = CORDIC_STEPS_DEF;
  localparam int     SHIFT       = 16 - FRAC;
  localparam longint ROLL_LIMIT  = longint'(180) <<< FRAC;
  localparam longint PITCH_LIMIT = longint'(90) <<< FRAC;

  typedef struct {
    level_t                    level;
    logic [DWELL_W-1:0]        dwell;
    logic signed [ROLL_W-1:0]  roll;
    logic signed [PITCH_W-1:0] pitch;
    logic [SEC_W-1:0]          secs;
    logic [MIN_W-1:0]          mins;
    logic [HOUR_W-1:0]         hours;
  } reading_t;

  reading_t pending_readings[$];
  longint   arctan_step [TABLE_LEN];

  logic signed [CFG_W-1:0] thr_high;
  logic signed [CFG_W-1:0] roll_floor;
  logic signed [CFG_W-1:0] roll_ceil;
  logic signed [CFG_W-1:0] pitch_floor;
  logic signed [CFG_W-1:0] pitch_ceil;

  level_t             prev_level;
  logic [DWELL_W-1:0] run_length;
  logic [SEC_W-1:0]   secs;
  logic [MIN_W-1:0]   mins;
  logic [HOUR_W-1:0]  hours;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    arctan_step = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                    14668, 7334, 3667, 1833, 917, 458, 229, 115,
                    57, 29, 14, 7, 4, 2, 1, 0};
  end

  // Angle of (vx, vy) in degrees scaled by 2^16, with the final x as length.
  function automatic longint vector_angle(input longint vx, input longint vy,
                                          output longint length);
    longint x, y, acc, t, xs, ys;
    x   = vx;
    y   = vy;
    acc = 0;
    if (x == 0 && y == 0) begin
      length = 0;
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x   = y;
        y   = -t;
        acc = longint'(DEG90_Q16);
      end else begin
        x   = -y;
        y   = t;
        acc = -longint'(DEG90_Q16);
      end
    end
    for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        acc = acc + arctan_step[i];
      end else begin
        x   = x - ys;
        y   = y + xs;
        acc = acc - arctan_step[i];
      end
    end
    length = x;
    return acc;
  endfunction

  function automatic longint to_scaled(input longint a, input longint lim);
    longint r;
    r = (a + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic reading_t predict_reading(input logic signed [SAMPLE_W-1:0] ax,
                                               input logic signed [SAMPLE_W-1:0] ay,
                                               input logic signed [SAMPLE_W-1:0] az);
    longint   gx, gy, gz, span, spare, horiz, roll, pitch;
    level_t   level;
    reading_t r;
    gx    = longint'(ax) <<< GUARD_BITS;
    gy    = longint'(ay) <<< GUARD_BITS;
    gz    = longint'(az) <<< GUARD_BITS;
    roll  = vector_angle(gz, gy, span);
    horiz = (span * longint'(INV_GAIN_Q16)) >>> GAIN_FRAC;
    pitch = vector_angle(horiz, -gx, spare);
    roll  = to_scaled(roll, ROLL_LIMIT);
    pitch = to_scaled(pitch, PITCH_LIMIT);

    if (roll > thr_high || pitch > thr_high) begin
      level = LVL_HIGH;
    end else if (roll > roll_floor && roll < roll_ceil &&
                 pitch > pitch_floor && pitch < pitch_ceil) begin
      level = LVL_REST;
    end else begin
      level = LVL_ACTIVE;
    end

    if (level != prev_level) begin
      run_length = 1;
    end else if (run_length != '1) begin
      run_length = run_length + 1'b1;
    end
    prev_level = level;

    secs = secs + 1'b1;
    if (secs == SEC_W'(SECS_PER_MIN)) begin
      secs = '0;
      mins = mins + 1'b1;
      if (mins == MIN_W'(MINS_PER_HOUR)) begin
        mins = '0;
        if (hours != '1) hours = hours + 1'b1;
      end
    end

    r.level = level;
    r.dwell = run_length;
    r.roll  = ROLL_W'(roll);
    r.pitch = PITCH_W'(pitch);
    r.secs  = secs;
    r.mins  = mins;
    r.hours = hours;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      thr_high    = 16'sd1280;
      roll_floor  = -16'sd640;
      roll_ceil   = 16'sd256;
      pitch_floor = -16'sd384;
      pitch_ceil  = 16'sd384;
      prev_level  = LVL_REST;
      run_length  = '0;
      secs        = '0;
      mins        = '0;
      hours       = '0;
      pending_readings.delete();
      outstanding = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_ACTIVE_THR: thr_high    = cfg_ch.data;
          REG_ROLL_LO:    roll_floor  = cfg_ch.data;
          REG_ROLL_HI:    roll_ceil   = cfg_ch.data;
          REG_PITCH_LO:   pitch_floor = cfg_ch.data;
          REG_PITCH_HI:   pitch_ceil  = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_readings.size() == 0) begin
          $error("result beat arrived with no sample waiting for it");
          mismatches++;
        end else begin
          want = pending_readings.pop_front();
          check_field("activity_level", want.level, out_ch.activity_level);
          check_field("dwell_seconds", want.dwell, out_ch.dwell_seconds);
          check_field("roll_angle", want.roll, out_ch.roll_angle);
          check_field("pitch_angle", want.pitch, out_ch.pitch_angle);
          check_field("elapsed_seconds", want.secs, out_ch.elapsed_seconds);
          check_field("elapsed_minutes", want.mins, out_ch.elapsed_minutes);
          check_field("elapsed_hours", want.hours, out_ch.elapsed_hours);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_readings.push_back(predict_reading(in_ch.accel_x, in_ch.accel_y,
                                                   in_ch.accel_z));
      end
      outstanding = pending_readings.size();
    end
  end

endmodule

// File: verif/tilt_activity_classifier_test.sv
module tilt_activity_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tac_pkg::*;

  localparam int RUN_LIMIT   = 1_000_000;
  localparam int LONG_HOLD   = 600;
  localparam int SETTLE      = 2 * CORDIC_STEPS_DEF + 10;
  localparam int PHASE_ITEMS = 100;
  localparam int ITEM_TARGET = 540;
  localparam int IDLE_PCT    = 35;
  localparam int ANGLE_SPAN  = 23040;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk;
  logic rst_n;
  bit   steady;
  bit   hold_asked;
  int   cycles = 0;
  int   samples_sent = 0;
  int   mismatches;
  int   outstanding;
  int   prev_x, prev_y, prev_z;

  tac_in_if  in_bus();
  tac_out_if out_bus();
  tac_cfg_if cfg_bus();

  tilt_activity_classifier dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_bus),
    .out_s (out_bus),
    .cfg_s (cfg_bus)
  );

  tilt_activity_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_ch      (cfg_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // The result side stalls at random, and once for a long stretch on request.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked) begin
        out_bus.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_asked = 1'b0;
      end
      out_bus.ready = steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_sample(input int x, input int y, input int z);
    @(negedge clk);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(45, 1)) @(negedge clk);
    end
    in_bus.valid   = 1'b1;
    in_bus.accel_x = SAMPLE_W'(x);
    in_bus.accel_y = SAMPLE_W'(y);
    in_bus.accel_z = SAMPLE_W'(z);
    prev_x = x;
    prev_y = y;
    prev_z = z;
    do @(posedge clk); while (!in_bus.ready);
    samples_sent++;
  endtask

  task automatic wait_drained;
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = CFG_W'(value);
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic write_limits(input int thr, input int rl, input int rh, input int pl,
                              input int ph);
    write_reg(REG_ACTIVE_THR, thr);
    write_reg(REG_ROLL_LO, rl);
    write_reg(REG_ROLL_HI, rh);
    write_reg(REG_PITCH_LO, pl);
    write_reg(REG_PITCH_HI, ph);
  endtask

  function automatic int any_angle();
    return int'($urandom_range(2 * ANGLE_SPAN)) - ANGLE_SPAN;
  endfunction

  function automatic int small_tilt();
    return int'($urandom_range(2400)) - 1200;
  endfunction

  function automatic int corner_value();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return 32767;
    endcase
  endfunction

  // Near-level and repeated readings so all three classes and long dwell runs occur.
  task automatic random_sample;
    int mode;
    mode = $urandom_range(99);
    if (mode < 40) begin
      send_sample(small_tilt(), small_tilt(), $urandom_range(16384, 6000));
    end else if (mode < 60) begin
      send_sample(prev_x, prev_y, prev_z);
    end else if (mode < 85) begin
      send_sample(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                  int'($urandom_range(65535)) - 32768);
    end else begin
      send_sample(corner_value(), corner_value(), corner_value());
    end
  endtask

  task automatic run_random(input int count);
    repeat (count) random_sample();
  endtask

  initial begin
    rst_n          = 1'b0;
    steady         = 1'b0;
    hold_asked     = 1'b0;
    prev_x         = 0;
    prev_y         = 0;
    prev_z         = 16384;
    in_bus.valid   = 1'b0;
    in_bus.accel_x = '0;
    in_bus.accel_y = '0;
    in_bus.accel_z = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_ACTIVE_THR;
    cfg_bus.data   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_sample(0, 0, 0);
    send_sample(0, 0, 16384);
    send_sample(0, 0, 16384);
    send_sample(0, 0, -16384);
    send_sample(0, -1, -16384);
    send_sample(0, 1, -16384);
    send_sample(32767, 0, 0);
    send_sample(-32768, 0, 0);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, 32767, -32768);
    send_sample(32767, -32768, 32767);
    send_sample(0, 16384, 0);
    send_sample(0, -16384, 0);
    send_sample(-400, 0, 16384);
    send_sample(0, -1000, 16384);
    send_sample(0, 700, 16384);
    send_sample(-3000, 0, 16384);
    send_sample(-2880, 0, 16384);
    send_sample(1, 1, 1);
    send_sample(-1, -1, -1);
    send_sample(0, 0, 1);
    send_sample(0, 0, -1);
    wait_drained();

    write_limits(any_angle(), any_angle(), any_angle(), any_angle(), any_angle());
    write_reg(REG_UNUSED, 16'h8000);
    run_random(PHASE_ITEMS);
    wait_drained();

    write_limits(ANGLE_SPAN, -ANGLE_SPAN, ANGLE_SPAN, -ANGLE_SPAN, ANGLE_SPAN);
    steady = 1'b1;
    run_random(PHASE_ITEMS);
    steady = 1'b0;
    wait_drained();

    write_limits(-ANGLE_SPAN, ANGLE_SPAN, -ANGLE_SPAN, ANGLE_SPAN, -ANGLE_SPAN);
    run_random(PHASE_ITEMS / 2);
    wait_drained();
    run_random(PHASE_ITEMS / 2);
    wait_drained();

    write_limits(640, -128, 128, -128, 128);
    run_random(20);
    hold_asked = 1'b1;
    run_random(PHASE_ITEMS - 20);
    wait_drained();

    write_limits(1280, -640, 256, -384, 384);
    run_random(PHASE_ITEMS);
    steady = 1'b1;
    while (samples_sent < ITEM_TARGET) random_sample();
    steady = 1'b0;
    wait_drained();

    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/tac_pkg.sv
design/tac_ifs.sv
design/tac_cfg.sv
design/tac_ctrl.sv
design/tac_dp.sv
design/tilt_activity_classifier.sv
verif/tilt_activity_checker.sv
verif/tilt_activity_classifier_test.sv
